@@ sv/nsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nsp_pkg;

    // Fixed field widths of the byte stream.
    localparam int BYTE_W = 8;
    localparam int PLEN_W = 21;

    // Byte values that make up a start code.
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_SC   = 8'h01;

    // A code counts only if at least this many bytes remain from its first byte on.
    localparam int MIN_TAIL = 5;

    // Zero run saturates here, which marks the start of a 4-byte code.
    localparam logic [1:0] ZRUN_MAX = 2'd3;
    localparam logic [1:0] ZRUN_SC  = 2'd2;

    typedef enum logic {
        EV_CODE = 1'b0,
        EV_LAST = 1'b1
    } nsp_ev_kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } nsp_q_stat_t;

endpackage

`default_nettype wire

@@ sv/nsp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nsp_front #(
    parameter int OFFSET_WIDTH = 20,
    localparam int EV_W = 1 + 2 * OFFSET_WIDTH + nsp_pkg::PLEN_W
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [nsp_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic [nsp_pkg::PLEN_W-1:0]  packet_length,
    input  wire logic                        last_byte,
    input  wire nsp_pkg::nsp_q_stat_t        q_stat,
    output logic                             ev_push,
    output logic [EV_W-1:0]                  ev_data
);

    import nsp_pkg::*;

    localparam int CW = ((OFFSET_WIDTH + 1 > PLEN_W) ? OFFSET_WIDTH + 1 : PLEN_W) + 1;

    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] pos_next;
    logic [1:0]              zrun_reg;
    logic [1:0]              zrun_next;

    logic                    beat;
    logic                    is_start;
    logic [OFFSET_WIDTH-1:0] back_dist;
    logic [OFFSET_WIDTH-1:0] code_pos;
    logic [OFFSET_WIDTH-1:0] next_start;
    logic                    in_range;
    logic                    counted;
    nsp_ev_kind_t            kind;

    assign s_tready = !q_stat.full;

    always_comb
    begin
        beat       = s_tvalid && s_tready;
        is_start   = (data_byte == BYTE_SC) && (zrun_reg >= ZRUN_SC);
        // A saturated run means the 4-byte form began one byte earlier.
        back_dist  = (zrun_reg == ZRUN_MAX) ? OFFSET_WIDTH'(3) : OFFSET_WIDTH'(2);
        code_pos   = pos_reg - back_dist;
        next_start = pos_reg + OFFSET_WIDTH'(1);
        in_range   = (CW'(code_pos) + CW'(MIN_TAIL)) <= CW'(packet_length);
        counted    = is_start && (pos_reg >= back_dist) && in_range;
        kind       = last_byte ? EV_LAST : EV_CODE;
        ev_push    = beat && (last_byte || counted);
        ev_data    = {kind, code_pos, next_start, packet_length};

        pos_next  = pos_reg;
        zrun_next = zrun_reg;
        if (beat)
        begin
            if (last_byte)
            begin
                pos_next  = '0;
                zrun_next = '0;
            end
            else
            begin
                pos_next = next_start;
                if (data_byte == BYTE_ZERO)
                begin
                    zrun_next = (zrun_reg == ZRUN_MAX) ? ZRUN_MAX : zrun_reg + 2'd1;
                end
                else
                begin
                    zrun_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            zrun_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            zrun_reg <= zrun_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/nsp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nsp_fifo #(
    parameter int DATA_W = 62,
    parameter int DEPTH  = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output nsp_pkg::nsp_q_stat_t   q_stat
);

    import nsp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [AW:0]       count_reg;
    logic [AW:0]       count_next;

    always_comb
    begin
        q_stat.full  = (count_reg == (AW + 1)'(DEPTH));
        q_stat.empty = (count_reg == '0);
        pop_data     = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (AW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/nsp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nsp_back #(
    parameter int OFFSET_WIDTH = 20,
    localparam int EV_W = 1 + 2 * OFFSET_WIDTH + nsp_pkg::PLEN_W
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire nsp_pkg::nsp_q_stat_t      q_stat,
    input  wire logic [EV_W-1:0]           ev_data,
    output logic                           ev_pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [OFFSET_WIDTH-1:0]        nal_offset,
    output logic [OFFSET_WIDTH:0]          nal_length,
    output logic                           last_nal,
    output logic                           no_start_code
);

    import nsp_pkg::*;

    localparam int CW = ((OFFSET_WIDTH + 1 > PLEN_W) ? OFFSET_WIDTH + 1 : PLEN_W) + 1;
    localparam int LW = OFFSET_WIDTH + 1;

    nsp_ev_kind_t            kind;
    logic [OFFSET_WIDTH-1:0] code_pos;
    logic [OFFSET_WIDTH-1:0] new_start;
    logic [PLEN_W-1:0]       plen;
    logic [LW-1:0]           last_len;
    logic [LW-1:0]           code_len;

    logic                    valid_reg;
    logic                    valid_next;
    logic [OFFSET_WIDTH-1:0] off_reg;
    logic [OFFSET_WIDTH-1:0] off_next;
    logic [LW-1:0]           len_reg;
    logic [LW-1:0]           len_next;
    logic                    last_reg;
    logic                    last_next;
    logic                    nsc_reg;
    logic                    nsc_next;
    logic                    found_reg;
    logic                    found_next;
    logic [OFFSET_WIDTH-1:0] ustart_reg;
    logic [OFFSET_WIDTH-1:0] ustart_next;

    always_comb
    begin
        kind      = nsp_ev_kind_t'(ev_data[EV_W-1]);
        code_pos  = ev_data[EV_W-2 -: OFFSET_WIDTH];
        new_start = ev_data[OFFSET_WIDTH+PLEN_W-1 -: OFFSET_WIDTH];
        plen      = ev_data[PLEN_W-1:0];

        // Both lengths clamp at zero when the unit start lies beyond the end point.
        last_len = (CW'(plen) > CW'(ustart_reg)) ? LW'(CW'(plen) - CW'(ustart_reg)) : '0;
        code_len = (code_pos >= ustart_reg) ? {1'b0, code_pos - ustart_reg} : '0;

        // The output register takes a new result when empty or being drained.
        ev_pop = !q_stat.empty && (!valid_reg || m_tready);

        valid_next  = valid_reg && !m_tready;
        off_next    = off_reg;
        len_next    = len_reg;
        last_next   = last_reg;
        nsc_next    = nsc_reg;
        found_next  = found_reg;
        ustart_next = ustart_reg;

        if (ev_pop)
        begin
            unique case (kind)
                EV_LAST:
                begin
                    valid_next  = 1'b1;
                    off_next    = found_reg ? ustart_reg : '0;
                    len_next    = found_reg ? last_len : '0;
                    last_next   = 1'b1;
                    nsc_next    = !found_reg;
                    found_next  = 1'b0;
                    ustart_next = '0;
                end
                EV_CODE:
                begin
                    valid_next  = found_reg;
                    off_next    = ustart_reg;
                    len_next    = code_len;
                    last_next   = 1'b0;
                    nsc_next    = 1'b0;
                    found_next  = 1'b1;
                    ustart_next = new_start;
                end
                default:
                begin
                    valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            found_reg  <= 1'b0;
            ustart_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            found_reg  <= found_next;
            ustart_reg <= ustart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        len_reg  <= len_next;
        last_reg <= last_next;
        nsc_reg  <= nsc_next;
    end

    assign m_tvalid      = valid_reg;
    assign nal_offset    = off_reg;
    assign nal_length    = len_reg;
    assign last_nal      = last_reg;
    assign no_start_code = nsc_reg;

endmodule

`default_nettype wire

@@ sv/annexb_nal_splitter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Results: each event from a beat is written into the event queue, then popped into the output
// register, whose valid flag drives m_tvalid; the result is taken while m_tready is high.
// Throughput: one byte per clock; a short event queue between the byte classifier and
// the result stage absorbs master-side stalls, and s_tready drops only when it is full.
// Reset: rst_n is asynchronous and active low; it clears the byte position, zero run,
// unit state, queue and output valid. No clearing pass is needed after reset.
module annexb_nal_splitter_core #(
    parameter int OFFSET_WIDTH = 20,
    parameter int FIFO_DEPTH   = 4,
    localparam int S_DATA_W = ((nsp_pkg::BYTE_W + nsp_pkg::PLEN_W + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * OFFSET_WIDTH + 1 + 7) / 8) * 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // data_byte [7:0], packet_length [28:8], zero fill above.
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // last_byte.
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // nal_offset [OFFSET_WIDTH-1:0], nal_length [2*OFFSET_WIDTH:OFFSET_WIDTH], zero fill.
    output logic [M_DATA_W-1:0]      m_tdata,
    // last_nal.
    output logic                     m_tlast,
    // no_start_code.
    output logic                     m_tuser
);

    import nsp_pkg::*;

    localparam int EV_W  = 1 + 2 * OFFSET_WIDTH + PLEN_W;
    localparam int M_PAD = M_DATA_W - (2 * OFFSET_WIDTH + 1);

    logic                    ev_push;
    logic                    ev_pop;
    logic [EV_W-1:0]         ev_in;
    logic [EV_W-1:0]         ev_out;
    nsp_q_stat_t             q_stat;
    logic [OFFSET_WIDTH-1:0] nal_offset;
    logic [OFFSET_WIDTH:0]   nal_length;

    nsp_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .data_byte     (s_tdata[BYTE_W-1:0]),
        .packet_length (s_tdata[BYTE_W+PLEN_W-1:BYTE_W]),
        .last_byte     (s_tlast),
        .q_stat        (q_stat),
        .ev_push       (ev_push),
        .ev_data       (ev_in)
    );

    nsp_fifo #(
        .DATA_W (EV_W),
        .DEPTH  (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev_push),
        .push_data (ev_in),
        .pop       (ev_pop),
        .pop_data  (ev_out),
        .q_stat    (q_stat)
    );

    nsp_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .ev_data       (ev_out),
        .ev_pop        (ev_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .nal_offset    (nal_offset),
        .nal_length    (nal_length),
        .last_nal      (m_tlast),
        .no_start_code (m_tuser)
    );

    assign m_tdata = {{M_PAD{1'b0}}, nal_length, nal_offset};

    // A packet without a start code reports a zero offset and length on its final beat.
    a_nsc_final : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && nal_offset == '0 && nal_length == '0))
        else $error("no-start-code result is not a clean final beat");

    // The end-of-packet event always reaches the queue.
    a_last_queued : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !q_stat.empty)
        else $error("end-of-packet event missing from the queue");

    // Draining without filling frees a slot for the next byte.
    a_pop_frees : assert property (@(posedge clk) disable iff (!rst_n)
        (ev_pop && !ev_push) |=> !q_stat.full)
        else $error("queue still full after a pop");

endmodule

`default_nettype wire
